[rtl/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Phase encoding, status and command codes, error codes and the structs that
// pass between the parser, the note map and the top level.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int VLQ_W = 28;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_METATYPE,
    PH_LEN,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_STATUS     = 2'd1,
    ERR_NO_RUNNING = 2'd2
  } error_t;

  localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] META_EOT      = 8'h2F;

  localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
  localparam logic [3:0] CMD_PROGRAM   = 4'hC;
  localparam logic [3:0] CMD_CH_PRESS  = 4'hD;

  typedef struct packed {
    logic       upd;
    logic       set;
    logic       clr;
    logic [6:0] note;
  } note_req_t;

  typedef struct packed {
    logic [VLQ_W-1:0] delta_time;
    logic [7:0]       status_byte;
    logic [3:0]       channel_number;
    logic [6:0]       first_data;
    logic [6:0]       second_data;
    logic [VLQ_W-1:0] payload_length;
    logic [31:0]      payload_value;
    logic             end_of_track;
    error_t           error_code;
    logic [7:0]       held_notes;
  } result_t;

endpackage

[rtl/mtep_note_map.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser note map
// One flag per note number and the count of notes marked on; the count after
// the current update is offered combinationally.
// ----------------------------------------------------------------------------
module mtep_note_map
  import mtep_pkg::*;
#(
  parameter int NOTE_COUNT = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  note_req_t req,
  output logic [7:0] held_next
);

  localparam int IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

  logic [NOTE_COUNT-1:0] note_map;
  logic [NOTE_COUNT-1:0] note_map_next;
  logic [7:0]            held;
  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  logic                  cur;

  assign in_range = ({25'd0, req.note} < 32'(NOTE_COUNT));
  assign idx      = IDX_W'(req.note);
  assign cur      = note_map[idx];

  always_comb begin
    note_map_next = note_map;
    held_next     = held;
    if (req.upd && in_range) begin
      if (req.set && !cur) begin
        note_map_next[idx] = 1'b1;
        held_next          = held + 8'd1;
      end else if (req.clr && cur) begin
        note_map_next[idx] = 1'b0;
        held_next          = held - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_map <= '0;
      held     <= '0;
    end else begin
      note_map <= note_map_next;
      held     <= held_next;
    end
  end

endmodule

[rtl/mtep_parser.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser phase logic
// Holds the parse phase, delta and length accumulators, running status and
// payload packing; decides the next state and the result for one byte.
// ----------------------------------------------------------------------------
module mtep_parser
  import mtep_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       restart,
  input  logic [7:0] held_next,
  output note_req_t  note_req,
  output logic       res_valid,
  output result_t    res
);

  phase_t           phase, phase_next;
  logic [VLQ_W-1:0] delta, delta_next;
  logic [7:0]       run_status, run_status_next;
  logic [7:0]       latch, latch_next;
  logic [VLQ_W-1:0] len, len_next;
  logic [31:0]      shift, shift_next;
  logic [7:0]       special, special_next;
  logic [VLQ_W-1:0] total, total_next;

  phase_t           cur_phase;
  logic [VLQ_W-1:0] cur_delta;
  logic [7:0]       cur_rs;
  logic [VLQ_W-1:0] len_acc;
  logic [VLQ_W-1:0] len_dec;
  logic [3:0]       cmd;
  logic             is_meta;
  logic [7:0]       rstat;
  logic [6:0]       rd1;
  logic [6:0]       rd2;
  logic [VLQ_W-1:0] rlen;
  logic [31:0]      rval;
  logic             reot;
  error_t           rerr;

  // a track start takes effect before the byte is decoded
  assign cur_phase = restart ? PH_DELTA : phase;
  assign cur_delta = restart ? '0 : delta;
  assign cur_rs    = restart ? '0 : run_status;
  assign cmd       = cur_rs[7:4];
  assign is_meta   = (special == STATUS_META);
  assign len_acc   = {len[VLQ_W-8:0], byte_in[6:0]};
  assign len_dec   = (len != '0) ? len - VLQ_W'(1) : '0;

  always_comb begin
    phase_next      = cur_phase;
    delta_next      = cur_delta;
    run_status_next = cur_rs;
    latch_next      = latch;
    len_next        = len;
    shift_next      = shift;
    special_next    = special;
    total_next      = total;
    note_req        = '0;
    res_valid       = 1'b0;
    rstat           = '0;
    rd1             = '0;
    rd2             = '0;
    rlen            = '0;
    rval            = '0;
    reot            = 1'b0;
    rerr            = ERR_NONE;

    unique case (cur_phase)
      PH_DELTA: begin
        delta_next = {cur_delta[VLQ_W-8:0], byte_in[6:0]};
        if (!byte_in[7]) phase_next = PH_STATUS;
      end
      PH_STATUS, PH_DATA1: begin
        if (cur_phase == PH_STATUS && byte_in[7]) begin
          if (byte_in < STATUS_SYSTEM) begin
            run_status_next = byte_in;
            phase_next      = PH_DATA1;
          end else if (byte_in == STATUS_SYSEX || byte_in == STATUS_ESCAPE) begin
            special_next    = byte_in;
            run_status_next = '0;
            latch_next      = '0;
            len_next        = '0;
            shift_next      = '0;
            phase_next      = PH_LEN;
          end else if (byte_in == STATUS_META) begin
            special_next    = byte_in;
            run_status_next = '0;
            phase_next      = PH_METATYPE;
          end else begin
            res_valid  = 1'b1;
            rstat      = byte_in;
            rerr       = ERR_STATUS;
            phase_next = PH_HALT;
          end
        end else if (cur_phase == PH_STATUS && cur_rs == '0) begin
          res_valid  = 1'b1;
          rerr       = ERR_NO_RUNNING;
          phase_next = PH_HALT;
        end else begin
          latch_next = {1'b0, byte_in[6:0]};
          if (cmd == CMD_PROGRAM || cmd == CMD_CH_PRESS) begin
            res_valid  = 1'b1;
            rstat      = cur_rs;
            rd1        = byte_in[6:0];
            phase_next = PH_DELTA;
            delta_next = '0;
          end else begin
            phase_next = PH_DATA2;
          end
        end
      end
      PH_DATA2: begin
        note_req.upd  = step;
        note_req.set  = (cmd == CMD_NOTE_ON);
        note_req.clr  = (cmd == CMD_NOTE_OFF);
        note_req.note = latch[6:0];
        res_valid     = 1'b1;
        rstat         = cur_rs;
        rd1           = latch[6:0];
        rd2           = byte_in[6:0];
        phase_next    = PH_DELTA;
        delta_next    = '0;
      end
      PH_METATYPE: begin
        latch_next = byte_in;
        len_next   = '0;
        shift_next = '0;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        len_next = len_acc;
        if (!byte_in[7]) begin
          total_next = len_acc;
          if (len_acc == '0) begin
            res_valid  = 1'b1;
            rstat      = special;
            rd1        = is_meta ? latch[6:0] : 7'd0;
            rlen       = len_acc;
            rval       = shift;
            reot       = is_meta && (latch == META_EOT);
            phase_next = PH_DELTA;
            delta_next = '0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        shift_next = {shift[23:0], byte_in};
        len_next   = len_dec;
        if (len_dec == '0) begin
          res_valid  = 1'b1;
          rstat      = special;
          rd1        = is_meta ? latch[6:0] : 7'd0;
          rlen       = total;
          rval       = {shift[23:0], byte_in};
          reot       = is_meta && (latch == META_EOT);
          phase_next = PH_DELTA;
          delta_next = '0;
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  always_comb begin
    res.delta_time     = cur_delta;
    res.status_byte    = rstat;
    res.channel_number = (rstat[7] && rstat < STATUS_SYSTEM) ? rstat[3:0] : 4'd0;
    res.first_data     = rd1;
    res.second_data    = rd2;
    res.payload_length = rlen;
    res.payload_value  = rval;
    res.end_of_track   = reot;
    res.error_code     = rerr;
    res.held_notes     = held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DELTA;
      delta      <= '0;
      run_status <= '0;
      latch      <= '0;
      len        <= '0;
      shift      <= '0;
      special    <= '0;
      total      <= '0;
    end else if (step) begin
      phase      <= phase_next;
      delta      <= delta_next;
      run_status <= run_status_next;
      latch      <= latch_next;
      len        <= len_next;
      shift      <= shift_next;
      special    <= special_next;
      total      <= total_next;
    end
  end

endmodule

[rtl/midi_track_event_parser_core.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Byte-at-a-time decoder for a standard MIDI file track body.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one track byte per transaction, with
//   track_start set on the first byte of a track to clear the phase, delta,
//   running status and error halt.
//   Output channel (out_valid/out_ready): one transaction per completed event
//   or per error; bytes in the middle of an event produce nothing.
//   Each accepted byte is held in the input register, decoded there against
//   the parser state, and its result lands in the output register, which
//   raises out_valid for the byte that completes the event.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   per-byte phase update is the only work and it fits between the input and
//   output registers.
//   A stalled receiver holds the output register; the input register then
//   drains only bytes that give no result, so input stalls after at most one
//   more byte that completes an event.
//   Reset clears the note map, held count and all parser state; the block
//   takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module midi_track_event_parser_core
  import mtep_pkg::*;
#(
  parameter int NOTE_COUNT = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       stream_byte,
  input  logic             track_start,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VLQ_W-1:0] delta_time,
  output logic [7:0]       status_byte,
  output logic [3:0]       channel_number,
  output logic [6:0]       first_data,
  output logic [6:0]       second_data,
  output logic [VLQ_W-1:0] payload_length,
  output logic [31:0]      payload_value,
  output logic             end_of_track,
  output logic [1:0]       error_code,
  output logic [7:0]       held_notes
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_go;
  logic       step;
  logic       out_free;
  logic       p_res_valid;
  result_t    p_res;
  result_t    out_res;
  note_req_t  note_req;
  logic [7:0] held_next;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = !p_res_valid || out_free;
  assign step     = s1_valid && s1_go;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= stream_byte;
      s1_start <= track_start;
    end
  end

  mtep_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (s1_byte),
    .restart   (s1_start),
    .held_next (held_next),
    .note_req  (note_req),
    .res_valid (p_res_valid),
    .res       (p_res)
  );

  mtep_note_map #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_note_map (
    .clk       (clk),
    .rst       (rst),
    .req       (note_req),
    .held_next (held_next)
  );

  // load a new result or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && p_res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && p_res_valid) begin
      out_res <= p_res;
    end
  end

  assign delta_time     = out_res.delta_time;
  assign status_byte    = out_res.status_byte;
  assign channel_number = out_res.channel_number;
  assign first_data     = out_res.first_data;
  assign second_data    = out_res.second_data;
  assign payload_length = out_res.payload_length;
  assign payload_value  = out_res.payload_value;
  assign end_of_track   = out_res.end_of_track;
  assign error_code     = out_res.error_code;
  assign held_notes     = out_res.held_notes;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_byte) && $stable(s1_start))
    else $error("input register lost a byte while blocked");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(step && p_res_valid))
    else $error("result register overwritten while stalled");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.held_notes <= 8'd128)
    else $error("held note count out of range");

  a_eot_meta: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.end_of_track |-> out_res.status_byte == STATUS_META)
    else $error("end of track on a non-meta event");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.error_code != ERR_NONE |->
      out_res.payload_length == '0 && out_res.first_data == '0 &&
      out_res.channel_number == '0 && !out_res.end_of_track)
    else $error("error result carries event fields");
`endif

endmodule

[bench/midi_track_event_parser_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Watches both channels of the parser core. Every accepted track byte is run
// through a local copy of the parse state; each completed event or error is
// queued and compared field by field with the next result the core hands out.
// ----------------------------------------------------------------------------
module midi_track_event_parser_checker
  import mtep_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       stream_byte,
  input  logic             track_start,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [VLQ_W-1:0] delta_time,
  input  logic [7:0]       status_byte,
  input  logic [3:0]       channel_number,
  input  logic [6:0]       first_data,
  input  logic [6:0]       second_data,
  input  logic [VLQ_W-1:0] payload_length,
  input  logic [31:0]      payload_value,
  input  logic             end_of_track,
  input  logic [1:0]       error_code,
  input  logic [7:0]       held_notes,
  output int               fail_count,
  output int               pending
);

  phase_t           phase;
  logic [VLQ_W-1:0] delta_acc;
  logic [7:0]       run_status;
  logic [7:0]       latched_byte;
  logic [VLQ_W-1:0] len_left;
  logic [VLQ_W-1:0] len_total;
  logic [31:0]      tail_bytes;
  logic [7:0]       special_status;
  logic [127:0]     note_map;
  logic [7:0]       held_count;

  result_t expected_events[$];
  int      mismatches;

  function automatic result_t pack_event(input logic [7:0] st, input logic [6:0] d1,
                                         input logic [6:0] d2,
                                         input logic [VLQ_W-1:0] len,
                                         input logic [31:0] val, input logic eot,
                                         input error_t err);
    result_t r;
    r.delta_time     = delta_acc;
    r.status_byte    = st;
    r.channel_number = (st[7] && st < STATUS_SYSTEM) ? st[3:0] : 4'h0;
    r.first_data     = d1;
    r.second_data    = d2;
    r.payload_length = len;
    r.payload_value  = val;
    r.end_of_track   = eot;
    r.error_code     = err;
    r.held_notes     = held_count;
    return r;
  endfunction

  function automatic result_t close_event(input logic [7:0] st, input logic [6:0] d1,
                                          input logic [6:0] d2,
                                          input logic [VLQ_W-1:0] len,
                                          input logic [31:0] val, input logic eot);
    result_t r;
    r = pack_event(st, d1, d2, len, val, eot, ERR_NONE);
    phase     = PH_DELTA;
    delta_acc = '0;
    return r;
  endfunction

  function automatic result_t raise_fault(input logic [7:0] st, input error_t err);
    result_t r;
    r = pack_event(st, 7'd0, 7'd0, '0, 32'd0, 1'b0, err);
    phase = PH_HALT;
    return r;
  endfunction

  function automatic result_t close_special();
    logic       meta;
    logic [6:0] d1;
    meta = (special_status == STATUS_META);
    d1   = meta ? latched_byte[6:0] : 7'd0;
    return close_event(special_status, d1, 7'd0, len_total, tail_bytes,
                       meta && latched_byte == META_EOT);
  endfunction

  function automatic bit take_first_data(input logic [7:0] b, output result_t msg);
    logic [3:0] cmd;
    cmd          = run_status[7:4];
    latched_byte = {1'b0, b[6:0]};
    msg          = '0;
    if (cmd == CMD_PROGRAM || cmd == CMD_CH_PRESS) begin
      msg = close_event(run_status, b[6:0], 7'd0, '0, 32'd0, 1'b0);
      return 1'b1;
    end
    phase = PH_DATA2;
    return 1'b0;
  endfunction

  // Advance the parse state by one byte; return 1 when an event or error completes.
  function automatic bit parse_track_byte(input logic [7:0] b, input logic restart,
                                          output result_t msg);
    bit         got;
    logic [3:0] cmd;
    logic [6:0] note;
    got = 1'b0;
    msg = '0;
    if (restart) begin
      phase      = PH_DELTA;
      delta_acc  = '0;
      run_status = '0;
    end
    case (phase)
      PH_DELTA: begin
        delta_acc = {delta_acc[VLQ_W-8:0], b[6:0]};
        if (!b[7]) phase = PH_STATUS;
      end
      PH_STATUS: begin
        if (b[7]) begin
          if (b < STATUS_SYSTEM) begin
            run_status = b;
            phase      = PH_DATA1;
          end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
            special_status = b;
            run_status     = '0;
            latched_byte   = '0;
            len_left       = '0;
            tail_bytes     = '0;
            phase          = PH_LEN;
          end else if (b == STATUS_META) begin
            special_status = b;
            run_status     = '0;
            phase          = PH_METATYPE;
          end else begin
            msg = raise_fault(b, ERR_STATUS);
            got = 1'b1;
          end
        end else if (run_status == '0) begin
          msg = raise_fault(8'h00, ERR_NO_RUNNING);
          got = 1'b1;
        end else begin
          got = take_first_data(b, msg);
        end
      end
      PH_DATA1: got = take_first_data(b, msg);
      PH_DATA2: begin
        cmd  = run_status[7:4];
        note = latched_byte[6:0];
        // map bit and count move together; repeats leave both alone
        if (cmd == CMD_NOTE_ON && !note_map[note]) begin
          note_map[note] = 1'b1;
          held_count     = held_count + 8'd1;
        end else if (cmd == CMD_NOTE_OFF && note_map[note]) begin
          note_map[note] = 1'b0;
          held_count     = held_count - 8'd1;
        end
        msg = close_event(run_status, note, b[6:0], '0, 32'd0, 1'b0);
        got = 1'b1;
      end
      PH_METATYPE: begin
        latched_byte = b;
        len_left     = '0;
        tail_bytes   = '0;
        phase        = PH_LEN;
      end
      PH_LEN: begin
        len_left = {len_left[VLQ_W-8:0], b[6:0]};
        if (!b[7]) begin
          len_total = len_left;
          if (len_left == '0) begin
            msg = close_special();
            got = 1'b1;
          end else begin
            phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        tail_bytes = {tail_bytes[23:0], b};
        if (len_left != '0) len_left = len_left - VLQ_W'(1);
        if (len_left == '0) begin
          msg = close_special();
          got = 1'b1;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    result_t msg;
    if (rst) begin
      phase          = PH_DELTA;
      delta_acc      = '0;
      run_status     = '0;
      latched_byte   = '0;
      len_left       = '0;
      len_total      = '0;
      tail_bytes     = '0;
      special_status = '0;
      note_map       = '0;
      held_count     = '0;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("result with none expected: status_byte %0h, delta_time %0h",
                 status_byte, delta_time);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("delta_time", 32'(want.delta_time), 32'(delta_time));
          check_field("status_byte", 32'(want.status_byte), 32'(status_byte));
          check_field("channel_number", 32'(want.channel_number), 32'(channel_number));
          check_field("first_data", 32'(want.first_data), 32'(first_data));
          check_field("second_data", 32'(want.second_data), 32'(second_data));
          check_field("payload_length", 32'(want.payload_length), 32'(payload_length));
          check_field("payload_value", want.payload_value, payload_value);
          check_field("end_of_track", 32'(want.end_of_track), 32'(end_of_track));
          check_field("error_code", 32'(want.error_code), 32'(error_code));
          check_field("held_notes", 32'(want.held_notes), 32'(held_notes));
        end
      end
      if (in_valid && in_ready) begin
        if (parse_track_byte(stream_byte, track_start, msg)) expected_events.push_back(msg);
      end
    end
    pending    <= expected_events.size();
    fail_count <= mismatches;
  end

endmodule

[bench/tb_midi_track_event_parser_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser core testbench
// Feeds track bytes to the core: a short directed track, then random event
// streams (channel events with and without running status, sysex and meta
// with payloads, broken events, noise, error halts and track restarts) under
// three sender/receiver idle mixes, with a long receiver hold and drain
// pauses. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser_core;
  import mtep_pkg::*;

  localparam logic [3:0] CMD_POLY_PRESS = 4'hA;
  localparam logic [3:0] CMD_CONTROL    = 4'hB;
  localparam logic [3:0] CMD_PITCH      = 4'hE;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] STATUS_UNDEF   = 8'hF4;
  localparam int         LONG_HOLD      = 400;
  localparam int         STALL_LIMIT    = 4000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       stream_byte;
  logic             track_start;
  logic             out_valid;
  logic             out_ready;
  logic [VLQ_W-1:0] delta_time;
  logic [7:0]       status_byte;
  logic [3:0]       channel_number;
  logic [6:0]       first_data;
  logic [6:0]       second_data;
  logic [VLQ_W-1:0] payload_length;
  logic [31:0]      payload_value;
  logic             end_of_track;
  logic [1:0]       error_code;
  logic [7:0]       held_notes;
  int               fail_count;
  int               pending;

  int         sent;
  int         send_gap_pct;
  int         rcv_stall_pct;
  int         long_holds_asked;
  int         long_holds_done;
  int         hold_left;
  int         quiet_cycles;
  bit         need_start;
  bit         rs_live;
  logic [3:0] rs_cmd;

  midi_track_event_parser_core dut (.*);

  midi_track_event_parser_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold whenever one is requested
  initial begin
    out_ready       = 1'b0;
    long_holds_done = 0;
    hold_left       = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (long_holds_done != long_holds_asked) begin
        long_holds_done++;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("midi_track_event_parser_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte; hold it until the transaction completes.
  task automatic put(input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    track_start <= need_start;
    if (need_start) rs_live = 1'b0;
    need_start = 1'b0;
    if (counted) sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_number(input longint unsigned v, input int nb);
    logic [6:0] grp;
    for (int i = nb - 1; i >= 0; i--) begin
      grp = 7'(v >> (7 * i));
      put({i != 0, grp}, 1'b1);
    end
  endtask

  task automatic put_delta();
    int         r;
    int         nb;
    logic [6:0] grp;
    r  = $urandom_range(99);
    nb = (r < 60) ? 1 : (r < 94) ? $urandom_range(4, 2) : 5;
    for (int i = nb - 1; i >= 0; i--) begin
      grp = 7'($urandom_range(127));
      put({i != 0, grp}, 1'b1);
    end
  endtask

  // Length (sometimes padded, sometimes with bits above 28) and the payload.
  task automatic put_body();
    int              r;
    int              len;
    int              nb;
    longint unsigned v;
    longint unsigned hi;
    r   = $urandom_range(99);
    len = (r < 10) ? $urandom_range(20, 7) : $urandom_range(5);
    v   = 64'(len);
    nb  = 1;
    if (r >= 90) begin
      nb = 5;
      hi = 64'($urandom_range(127, 1));
      v  = v | (hi << 28);
    end else if (r >= 75) begin
      nb = $urandom_range(3, 2);
    end
    put_number(v, nb);
    repeat (len) put(8'($urandom_range(255)), 1'b1);
  endtask

  // Bytes after a halt are ignored by the parser; restart the track after them.
  task automatic put_halted_bytes();
    repeat ($urandom_range(3)) put(8'($urandom_range(255)), 1'b0);
    need_start = 1'b1;
  endtask

  task automatic put_channel_event();
    int         r;
    logic [3:0] cmd;
    logic [7:0] d1;
    logic [7:0] d2;
    bit         running;
    put_delta();
    running = rs_live && ($urandom_range(99) < 40);
    if (running) begin
      cmd = rs_cmd;
    end else begin
      r = $urandom_range(10);
      case (r)
        0, 1, 2: cmd = CMD_NOTE_OFF;
        3, 4, 5: cmd = CMD_NOTE_ON;
        6:       cmd = CMD_POLY_PRESS;
        7:       cmd = CMD_CONTROL;
        8:       cmd = CMD_PROGRAM;
        9:       cmd = CMD_CH_PRESS;
        default: cmd = CMD_PITCH;
      endcase
      put({cmd, 4'($urandom_range(15))}, 1'b1);
      rs_live = 1'b1;
      rs_cmd  = cmd;
    end
    // keep notes in a narrow band so ons and offs collide
    if ((cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) && $urandom_range(99) < 80)
      d1 = 8'(60 + $urandom_range(7));
    else
      d1 = 8'($urandom_range(127));
    if (!running && $urandom_range(9) == 0) d1[7] = 1'b1;
    put(d1, 1'b1);
    if (cmd != CMD_PROGRAM && cmd != CMD_CH_PRESS) begin
      d2 = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
      put(d2, 1'b1);
    end
  endtask

  task automatic put_meta_event();
    int r;
    put_delta();
    put(STATUS_META, 1'b1);
    r = $urandom_range(99);
    if (r < 15)      put(META_EOT, 1'b1);
    else if (r < 30) put(META_TEMPO, 1'b1);
    else             put(8'($urandom_range(255)), 1'b1);
    put_body();
    rs_live = 1'b0;
  endtask

  task automatic put_random_event();
    int         r;
    logic [7:0] b;
    if ($urandom_range(19) == 0) need_start = 1'b1;
    r = $urandom_range(99);
    if (r < 55) begin
      put_channel_event();
    end else if (r < 65) begin
      put_delta();
      put($urandom_range(1) ? STATUS_SYSEX : STATUS_ESCAPE, 1'b1);
      put_body();
      rs_live = 1'b0;
    end else if (r < 80) begin
      put_meta_event();
    end else if (r < 86) begin
      put_delta();
      do b = 8'($urandom_range(8'hFE, 8'hF1)); while (b == STATUS_ESCAPE);
      put(b, 1'b1);
      put_halted_bytes();
    end else if (r < 90) begin
      // data byte right after a restart: no running status to apply
      need_start = 1'b1;
      put_delta();
      put(8'($urandom_range(127)), 1'b1);
      put_halted_bytes();
    end else if (r < 95) begin
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(7) == 0) need_start = 1'b1;
        put(8'($urandom_range(255)), 1'b1);
      end
      need_start = 1'b1;
    end else begin
      // event cut short by a track restart
      put_delta();
      put(8'($urandom_range(8'hFF, 8'h80)), 1'b1);
      if ($urandom_range(1)) put(8'($urandom_range(255)), 1'b1);
      need_start = 1'b1;
    end
  endtask

  // Turn on every note once under running status.
  task automatic put_note_sweep();
    need_start = 1'b1;
    put(8'h00, 1'b1);
    put({CMD_NOTE_ON, 4'($urandom_range(15))}, 1'b1);
    for (int n = 0; n < 128; n++) begin
      if (n != 0) put(8'h00, 1'b1);
      put(8'(n), 1'b1);
      put(8'($urandom_range(127)), 1'b1);
    end
    rs_live = 1'b1;
    rs_cmd  = CMD_NOTE_ON;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    rst              = 1'b1;
    in_valid         = 1'b0;
    stream_byte      = 8'h00;
    track_start      = 1'b0;
    sent             = 0;
    send_gap_pct     = 25;
    rcv_stall_pct    = 74;
    long_holds_asked = 0;
    need_start       = 1'b1;
    rs_live          = 1'b0;
    rs_cmd           = CMD_NOTE_ON;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // note-on with velocity zero, repeated note-on under running status, note-off
    put(8'h00, 1'b1); put({CMD_NOTE_ON, 4'h0}, 1'b1); put(8'h3C, 1'b1); put(8'h00, 1'b1);
    put(8'h00, 1'b1); put(8'h3C, 1'b1); put(8'h40, 1'b1);
    put(8'h00, 1'b1); put({CMD_NOTE_OFF, 4'hF}, 1'b1); put(8'h3C, 1'b1); put(8'h7F, 1'b1);
    // largest delta, program change with bit 7 set on the data byte
    put(8'hFF, 1'b1); put(8'hFF, 1'b1); put(8'hFF, 1'b1); put(8'h7F, 1'b1);
    put({CMD_PROGRAM, 4'h5}, 1'b1); put(8'hFF, 1'b1);
    // tempo, then end of track
    put(8'h00, 1'b1); put(STATUS_META, 1'b1); put(META_TEMPO, 1'b1); put(8'h03, 1'b1);
    put(8'h07, 1'b1); put(8'hA1, 1'b1); put(8'h20, 1'b1);
    put(8'h00, 1'b1); put(STATUS_META, 1'b1); put(META_EOT, 1'b1); put(8'h00, 1'b1);
    // meta cancelled running status: data byte now faults and halts
    put(8'h00, 1'b1); put(8'h40, 1'b1); put(8'h00, 1'b0);
    need_start = 1'b1;
    put(8'h00, 1'b1); put(STATUS_UNDEF, 1'b1);
    need_start = 1'b1;

    while (sent < 550) put_random_event();
    wait_for_results();

    send_gap_pct = 74;
    rcv_stall_pct <= 25;
    while (sent < 1100) put_random_event();
    wait_for_results();

    send_gap_pct = 0;
    rcv_stall_pct <= 0;
    long_holds_asked <= long_holds_asked + 1;
    put_note_sweep();
    while (sent < 1650) put_random_event();
    wait_for_results();
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("midi_track_event_parser_core verification clean");
    else
      $display("midi_track_event_parser_core verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/mtep_pkg.sv
rtl/mtep_note_map.sv
rtl/mtep_parser.sv
rtl/midi_track_event_parser_core.sv
bench/midi_track_event_parser_checker.sv
bench/tb_midi_track_event_parser_core.sv
